// ----- rtl/ir_mcd_pkg.sv -----
// ---------------------------------------------------------------------------
// IR Manchester decoder package
// Shared types, register indexes and widths for the IR Manchester decoder.
// ---------------------------------------------------------------------------
package ir_mcd_pkg;

   // Number of bits in one received code, start bit included.
   localparam int CODE_BITS = 14;
   // Width of the command code field on the result channel.
   localparam int CMD_W     = 14;
   // Bit counter holds 0 .. CODE_BITS.
   localparam int COUNT_W   = $clog2(CODE_BITS + 1);

   localparam int DUR_W     = 16;
   localparam int BOUND_W   = 15;
   localparam int GAP_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT  = 3'd4;

   // Register reset values.
   localparam logic [BOUND_W-1:0] SHORT_LOW_RST  = 15'd444;
   localparam logic [BOUND_W-1:0] SHORT_HIGH_RST = 15'd1333;
   localparam logic [BOUND_W-1:0] LONG_LOW_RST   = 15'd1334;
   localparam logic [BOUND_W-1:0] LONG_HIGH_RST  = 15'd2222;
   localparam logic [GAP_W-1:0]   GAP_LIMIT_RST  = 16'd100;

   // Classified symbol of one duration.
   typedef enum logic [2:0] {
      SYM_NONE        = 3'd0,
      SYM_SHORT_PULSE = 3'd1,
      SYM_LONG_PULSE  = 3'd2,
      SYM_SHORT_SPACE = 3'd3,
      SYM_LONG_SPACE  = 3'd4
   } sym_type;

   // Manchester decoder state.
   typedef enum logic [4:0] {
      ST_BEGIN  = 5'b00001,
      ST_MID0   = 5'b00010,
      ST_MID1   = 5'b00100,
      ST_START0 = 5'b01000,
      ST_START1 = 5'b10000
   } state_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_BUSY     = 2'd0,
      STATUS_BAD_DUR  = 2'd1,
      STATUS_ILLEGAL  = 2'd2,
      STATUS_COMPLETE = 2'd3
   } status_type;

   // Configuration register set.
   typedef struct packed {
      logic [BOUND_W-1:0] short_low;
      logic [BOUND_W-1:0] short_high;
      logic [BOUND_W-1:0] long_low;
      logic [BOUND_W-1:0] long_high;
      logic [GAP_W-1:0]   gap_limit;
   } cfg_type;

   // One item after classification.
   typedef struct packed {
      logic    tick;
      logic    bstart;
      sym_type sym;
   } item_type;

   // One result word.
   typedef struct packed {
      status_type         status;
      logic [CMD_W-1:0]   code;
      logic               timed_out;
   } result_type;

endpackage

// ----- rtl/ir_mcd_csr.sv -----
// ---------------------------------------------------------------------------
// IR Manchester decoder configuration registers
// Holds the symbol bounds and the gap limit, written through a plain port.
// ---------------------------------------------------------------------------
module ir_mcd_csr
   import ir_mcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SHORT_LOW:  cfg_in.short_low  = csr_data[BOUND_W-1:0];
            CSR_SHORT_HIGH: cfg_in.short_high = csr_data[BOUND_W-1:0];
            CSR_LONG_LOW:   cfg_in.long_low   = csr_data[BOUND_W-1:0];
            CSR_LONG_HIGH:  cfg_in.long_high  = csr_data[BOUND_W-1:0];
            CSR_GAP_LIMIT:  cfg_in.gap_limit  = csr_data[GAP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_low  <= SHORT_LOW_RST;
         cfg_ff.short_high <= SHORT_HIGH_RST;
         cfg_ff.long_low   <= LONG_LOW_RST;
         cfg_ff.long_high  <= LONG_HIGH_RST;
         cfg_ff.gap_limit  <= GAP_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ir_mcd_classify.sv -----
// ---------------------------------------------------------------------------
// IR Manchester decoder duration classifier
// Turns a signed duration into a short or long pulse or space, or none.
// ---------------------------------------------------------------------------
module ir_mcd_classify
   import ir_mcd_pkg::*;
(
   input  logic [DUR_W-1:0] duration,
   input  cfg_type          cfg,
   output sym_type          sym
);

   logic             is_space;
   logic [DUR_W-1:0] mag;
   logic             in_short;
   logic             in_long;

   // Zero counts as a pulse of magnitude zero; the most negative value
   // has magnitude 32768, which the unsigned negation gives directly.
   assign is_space = (duration != '0) && !duration[DUR_W-1];
   assign mag      = duration[DUR_W-1] ? (~duration + 1'b1) : duration;

   // Exclusive bounds on both sides.
   assign in_short = (mag > {1'b0, cfg.short_low}) && (mag < {1'b0, cfg.short_high});
   assign in_long  = (mag > {1'b0, cfg.long_low})  && (mag < {1'b0, cfg.long_high});

   always_comb begin
      priority if (in_short) begin
         sym = is_space ? SYM_SHORT_SPACE : SYM_SHORT_PULSE;
      end else if (in_long) begin
         sym = is_space ? SYM_LONG_SPACE : SYM_LONG_PULSE;
      end else begin
         sym = SYM_NONE;
      end
   end

endmodule

// ----- rtl/ir_mcd_decode.sv -----
// ---------------------------------------------------------------------------
// IR Manchester decoder state machine
// Manchester state, bit collection and the millisecond gap counter.
// ---------------------------------------------------------------------------
module ir_mcd_decode
   import ir_mcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  item_type         item,
   input  logic [GAP_W-1:0] gap_limit,
   output result_type       result
);

   state_type              state_ff,  state_in;
   logic [COUNT_W-1:0]     count_ff,  count_in;
   logic [CODE_BITS-1:0]   code_ff,   code_in;
   logic [GAP_W-1:0]       gap_ff,    gap_in;

   // Next state of the decoder for the item in the input register.
   always_comb begin
      logic legal;
      logic push;
      logic push_bit;

      state_in         = state_ff;
      count_in         = count_ff;
      code_in          = code_ff;
      gap_in           = gap_ff;
      legal            = 1'b1;
      push             = 1'b0;
      push_bit         = 1'b0;
      result.status    = STATUS_BUSY;
      result.code      = '0;
      result.timed_out = 1'b0;

      if (item.tick) begin
         // Millisecond tick: saturating gap count, no result.
         if (gap_ff != '1) begin
            gap_in = gap_ff + 1'b1;
         end
      end else begin
         // A buffer that starts after a long gap drops any partial code.
         if (item.bstart) begin
            if (gap_ff > gap_limit) begin
               result.timed_out = (count_ff != '0);
               state_in         = ST_BEGIN;
               count_in         = '0;
               code_in          = '0;
            end
            gap_in = '0;
         end

         if (item.sym == SYM_NONE) begin
            result.status = STATUS_BAD_DUR;
            state_in      = ST_BEGIN;
            count_in      = '0;
            code_in       = '0;
         end else begin
            // The first symbol records the start bit and acts as in mid1.
            if (state_in == ST_BEGIN) begin
               state_in = ST_MID1;
               code_in  = {code_in[CODE_BITS-2:0], 1'b1};
               count_in = count_in + 1'b1;
            end

            unique case (state_in)
               ST_MID0: begin
                  if (item.sym == SYM_SHORT_SPACE) begin
                     state_in = ST_START0;
                  end else if (item.sym == SYM_LONG_SPACE) begin
                     state_in = ST_MID1;
                     push     = 1'b1;
                     push_bit = 1'b1;
                  end else begin
                     legal = 1'b0;
                  end
               end
               ST_MID1: begin
                  if (item.sym == SYM_SHORT_PULSE) begin
                     state_in = ST_START1;
                  end else if (item.sym == SYM_LONG_PULSE) begin
                     state_in = ST_MID0;
                     push     = 1'b1;
                  end else begin
                     legal = 1'b0;
                  end
               end
               ST_START0: begin
                  if (item.sym == SYM_SHORT_PULSE) begin
                     state_in = ST_MID0;
                     push     = 1'b1;
                  end else begin
                     legal = 1'b0;
                  end
               end
               ST_START1: begin
                  if (item.sym == SYM_SHORT_SPACE) begin
                     state_in = ST_MID1;
                     push     = 1'b1;
                     push_bit = 1'b1;
                  end else begin
                     legal = 1'b0;
                  end
               end
               default: begin
                  legal = 1'b0;
               end
            endcase

            if (push) begin
               code_in  = {code_in[CODE_BITS-2:0], push_bit};
               count_in = count_in + 1'b1;
            end

            if (!legal) begin
               result.status = STATUS_ILLEGAL;
               state_in      = ST_BEGIN;
               count_in      = '0;
               code_in       = '0;
            end else if (count_in >= COUNT_W'(CODE_BITS)) begin
               result.status = STATUS_COMPLETE;
               result.code   = CMD_W'(code_in);
               state_in      = ST_BEGIN;
               count_in      = '0;
               code_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BEGIN;
         count_ff <= '0;
         code_ff  <= '0;
         gap_ff   <= '0;
      end else if (go) begin
         state_ff <= state_in;
         count_ff <= count_in;
         code_ff  <= code_in;
         gap_ff   <= gap_in;
      end
   end

endmodule

// ----- rtl/ir_manchester_code_decoder.sv -----
// ---------------------------------------------------------------------------
// IR Manchester code decoder
// Classifies signed IR durations and decodes 14-bit Manchester codes.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   req     | req_valid/req_stall  | req_type, req_duration, req_buffer_start
//   rsp     | rsp_valid/rsp_stall  | rsp_status, rsp_command_code, rsp_timed_out
//   csr     | csr_write            | csr_index, csr_data
//
// One item is taken every cycle while the input is not stalled. A duration
// word is classified on its way into the input register and goes through
// the state machine into the result register when the input register
// moves on. Tick words update the gap counter and give no result.
// Reset is synchronous and restores the register defaults. A stalled result
// holds the result register; the input register then stalls only if it
// holds a duration.
// ---------------------------------------------------------------------------
module ir_manchester_code_decoder
   import ir_mcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [DUR_W-1:0]     req_duration,
   input  logic                 req_buffer_start,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [CMD_W-1:0]     rsp_command_code,
   output logic                 rsp_timed_out,

   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type    cfg;
   sym_type    sym;
   item_type   item_ff, item_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_go;
   logic       req_accept;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   ir_mcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ir_mcd_classify u_classify (
      .duration (req_duration),
      .cfg      (cfg),
      .sym      (sym)
   );

   // Input register moves on when it holds a tick or the result slot frees.
   assign s1_go      = s1_valid_ff && (item_ff.tick || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   assign item_in.tick   = req_type;
   assign item_in.bstart = req_buffer_start;
   assign item_in.sym    = sym;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
   end

   ir_mcd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .go        (s1_go),
      .item      (item_ff),
      .gap_limit (cfg.gap_limit),
      .result    (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && !item_ff.tick) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && !item_ff.tick) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_command_code = rsp_ff.code;
   assign rsp_timed_out    = rsp_ff.timed_out;

`ifndef ASSERT_OFF
   // The input side stalls only behind a full, stalled result register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without a stalled result");

   // A code is reported only with a completed command.
   a_code_only_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_COMPLETE)) |-> (rsp_command_code == '0))
      else $error("command code set on an incomplete result");

   // A taken result with no duration behind it leaves the output empty.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !(s1_go && !item_ff.tick)) |=> !rsp_valid)
      else $error("result repeated or invented");
`endif

endmodule
